[rtl/core/lnp_pkg.sv]
// Shared types and constants for the lexicographic permutation core.
package lnp_pkg;

    localparam int LETTER_SLOTS    = 8;
    localparam int LETTER_W        = 8;
    localparam int WORD_W          = LETTER_SLOTS * LETTER_W;
    localparam int LEN_W           = 4;
    localparam int SLOT_IDX_W      = $clog2(LETTER_SLOTS);
    localparam int KEY_W           = LETTER_W + 1;
    localparam int MAX_LETTERS_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic {
        FUNC_SORT = 1'b0,
        FUNC_NEXT = 1'b1
    } func_t;

    // One classified transaction as it travels from front to back.
    typedef struct packed {
        func_t                                    func;
        logic [LEN_W-1:0]                         len;
        logic                                     rise;
        logic [SLOT_IDX_W-1:0]                    k;
        logic [LETTER_SLOTS-1:0][LETTER_W-1:0]    letters;
    } item_t;

endpackage

[rtl/core/lnp_front.sv]
// Front stage: clamp the length, clear unused letters, find the last rise.
module lnp_front #(
    parameter int MAX_LETTERS = lnp_pkg::MAX_LETTERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [lnp_pkg::LEN_W-1:0]  word_len,
    input  logic [lnp_pkg::WORD_W-1:0] word_in,
    output lnp_pkg::item_t             push_item,
    output logic                       push_valid,
    input  logic                       push_stall
);
    import lnp_pkg::*;

    logic [LEN_W-1:0] len_c;
    item_t            item_c;
    item_t            item_reg;
    logic             valid_reg;
    logic             valid_next;
    logic             load;

    always_comb
    begin
        len_c = (word_len > LEN_W'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS) : word_len;
        item_c.func = func_t'(func);
        item_c.len  = len_c;
        item_c.rise = 1'b0;
        item_c.k    = '0;
        for (int i = 0; i < LETTER_SLOTS; i++)
        begin
            item_c.letters[i] = (LEN_W'(i) < len_c) ? word_in[i*LETTER_W +: LETTER_W] : '0;
        end
        // Last rise wins.
        for (int i = 0; i < LETTER_SLOTS - 1; i++)
        begin
            if ((LEN_W'(i + 1) < len_c) && (item_c.letters[i] < item_c.letters[i + 1]))
            begin
                item_c.rise = 1'b1;
                item_c.k    = SLOT_IDX_W'(i);
            end
        end
    end

    assign in_stall   = valid_reg && push_stall;
    assign load       = in_valid && !in_stall;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !push_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_c;
    end

endmodule

[rtl/core/lnp_fifo.sv]
// Short transaction queue between front and back.
module lnp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  lnp_pkg::item_t push_item,
    input  logic           push_valid,
    output logic           push_stall,
    output lnp_pkg::item_t pop_item,
    output logic           pop_valid,
    input  logic           pop_stall
);
    import lnp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign push_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/core/lnp_back.sv]
// Back pipeline: swap and tail reversal for a next request, or an odd-even transposition sort for a sort request.
module lnp_back #(
    parameter int MAX_LETTERS = lnp_pkg::MAX_LETTERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lnp_pkg::item_t             pop_item,
    input  logic                       pop_valid,
    output logic                       pop_stall,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lnp_pkg::WORD_W-1:0] word_out,
    output logic                       no_next
);
    import lnp_pkg::*;

    localparam int N          = MAX_LETTERS;
    localparam int NUM_STAGES = N + 1;

    typedef struct packed {
        logic                      sort;
        logic                      no_next;
        logic [N-1:0][KEY_W-1:0]   keys;
    } stage_t;

    stage_t                   stage_reg  [NUM_STAGES];
    stage_t                   stage_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]    valid_reg;
    logic [NUM_STAGES-1:0]    feed_valid;
    logic [NUM_STAGES:0]      ready;

    logic [LETTER_SLOTS-1:0][LETTER_W-1:0] swapped, perm;
    logic [SLOT_IDX_W-1:0]                 l_idx, r_idx;
    logic [LETTER_W-1:0]                   ak;
    logic [LEN_W:0]                        mirror;
    logic                                  do_next;

    // Swap a[k] with the last greater letter, then mirror the tail.
    always_comb
    begin
        do_next = (pop_item.func == FUNC_NEXT) && pop_item.rise;
        ak      = pop_item.letters[pop_item.k];
        l_idx   = pop_item.k;
        r_idx   = '0;
        mirror  = '0;
        for (int i = 0; i < LETTER_SLOTS; i++)
        begin
            if ((LEN_W'(i) > LEN_W'(pop_item.k)) && (LEN_W'(i) < pop_item.len)
                && (ak < pop_item.letters[i]))
                l_idx = SLOT_IDX_W'(i);
        end
        swapped           = pop_item.letters;
        swapped[pop_item.k] = pop_item.letters[l_idx];
        swapped[l_idx]    = ak;
        perm = swapped;
        for (int i = 0; i < LETTER_SLOTS; i++)
        begin
            if ((LEN_W'(i) > LEN_W'(pop_item.k)) && (LEN_W'(i) < pop_item.len))
            begin
                mirror  = {1'b0, pop_item.len} + (LEN_W+1)'(pop_item.k) - (LEN_W+1)'(i);
                r_idx   = mirror[SLOT_IDX_W-1:0];
                perm[i] = swapped[r_idx];
            end
        end
        if (!do_next)
            perm = pop_item.letters;

        stage_next[0].sort    = (pop_item.func == FUNC_SORT);
        stage_next[0].no_next = (pop_item.func == FUNC_NEXT) && !pop_item.rise;
        // Unused slots carry a high flag so the sort parks them at the top.
        for (int i = 0; i < N; i++)
        begin
            stage_next[0].keys[i] = {(LEN_W'(i) >= pop_item.len), perm[i]};
        end
    end

    genvar s;
    generate
        for (s = 1; s < NUM_STAGES; s++)
        begin : g_sort
            always_comb
            begin
                stage_next[s] = stage_reg[s-1];
                for (int j = ((s - 1) % 2); j + 1 < N; j += 2)
                begin
                    if (stage_reg[s-1].sort
                        && (stage_reg[s-1].keys[j] > stage_reg[s-1].keys[j+1]))
                    begin
                        stage_next[s].keys[j]   = stage_reg[s-1].keys[j+1];
                        stage_next[s].keys[j+1] = stage_reg[s-1].keys[j];
                    end
                end
            end
        end
    endgenerate

    assign ready[NUM_STAGES] = !out_stall;

    generate
        for (s = 0; s < NUM_STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_head
                assign feed_valid[s] = pop_valid;
            end
            else
            begin : g_body
                assign feed_valid[s] = valid_reg[s-1];
            end

            assign ready[s] = !valid_reg[s] || ready[s+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (ready[s])
                    valid_reg[s] <= feed_valid[s];
            end

            always_ff @(posedge clk)
            begin
                if (ready[s] && feed_valid[s])
                    stage_reg[s] <= stage_next[s];
            end
        end
    endgenerate

    assign pop_stall = !ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign no_next   = stage_reg[NUM_STAGES-1].no_next;

    genvar b;
    generate
        for (b = 0; b < LETTER_SLOTS; b++)
        begin : g_out
            if (b < N)
            begin : g_used
                assign word_out[b*LETTER_W +: LETTER_W] =
                    stage_reg[NUM_STAGES-1].keys[b][LETTER_W-1:0];
            end
            else
            begin : g_unused
                assign word_out[b*LETTER_W +: LETTER_W] = '0;
            end
        end
    endgenerate

endmodule

[rtl/core/lexicographic_next_permutation_core.sv]
// Top level of the lexicographic permutation core: front, queue and back pipeline.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------
//  in      | in_valid/in_stall  | func, word_len, word_in
//  out     | out_valid/out_stall| word_out, no_next
//
//  Throughput is one transaction per cycle while nothing stalls; the back
//  pipeline takes a new transaction every cycle while its stages flow.
//  A result passes the front register, one queue slot, the swap stage and
//  MAX_LETTERS compare-exchange stages of the sort network.
//  Reset clears every valid bit and the queue pointers; payload holds junk.
//  out_stall backs up the back pipeline; its stages, the two-entry queue and
//  the front register keep absorbing input until all fill, then in_stall rises.
module lexicographic_next_permutation_core #(
    parameter int MAX_LETTERS = lnp_pkg::MAX_LETTERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [lnp_pkg::LEN_W-1:0]  word_len,
    input  logic [lnp_pkg::WORD_W-1:0] word_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lnp_pkg::WORD_W-1:0] word_out,
    output logic                       no_next
);
    import lnp_pkg::*;

    // Front to queue.
    item_t push_item;
    logic  push_valid;
    logic  push_stall;

    // Queue to back.
    item_t pop_item;
    logic  pop_valid;
    logic  pop_stall;

    // Classify: clamp length, clear unused letters, locate the last rise.
    lnp_front #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .word_len   (word_len),
        .word_in    (word_in),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_stall (push_stall)
    );

    // Decouple the two halves so each can stall on its own.
    lnp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall)
    );

    // Carry out: next-permutation swap and reversal, or a full sort.
    lnp_back #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_stall (pop_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_out  (word_out),
        .no_next   (no_next)
    );

endmodule

[rtl/core/lnp_checker.sv]
// Port-level checker for the permutation core, bound to the top level.
module lnp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [lnp_pkg::WORD_W-1:0] word_out,
    input logic                       no_next
);
    import lnp_pkg::*;

    logic [4:0] pending_reg, pending_next;
    logic       in_acc, out_acc;
    logic       descending;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg + {4'd0, in_acc} - {4'd0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    always_comb
    begin
        descending = 1'b1;
        for (int i = 0; i < LETTER_SLOTS - 1; i++)
        begin
            if (word_out[i*LETTER_W +: LETTER_W] < word_out[(i+1)*LETTER_W +: LETTER_W])
                descending = 1'b0;
        end
    end

    // A last permutation has no rise anywhere in the word.
    a_last_is_descending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_next |-> descending)
        else $error("no_next raised on a word that still has a rise");

    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 5'd0)
        else $error("result shown with no transaction pending");

    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> pending_reg != 5'd0)
        else $error("input stalled while the core is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_out) && $stable(no_next))
        else $error("stalled result changed");

endmodule

bind lexicographic_next_permutation_core lnp_checker u_lnp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_out  (word_out),
    .no_next   (no_next)
);
